/* sv/bfa_pkg.sv */
package bfa_pkg;

  localparam int unsigned MaxBlocksDefault = 64;
  localparam int unsigned AddrBitsDefault  = 32;
  localparam int unsigned FieldW           = 32;
  localparam int unsigned OpW              = 3;
  localparam int unsigned StatusW          = 2;

  typedef enum logic [OpW-1:0] {
    OP_ALLOC    = 3'd0,
    OP_FREE     = 3'd1,
    OP_CONTAINS = 3'd2,
    OP_RESIZE   = 3'd3,
    OP_RESET    = 3'd4
  } op_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_NOROOM   = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

endpackage

/* sv/best_fit_block_allocator.sv */
// The scan reads one entry a cycle; an insert or an erase moves one entry a cycle, and a free
// that merges on both sides erases twice.
// Throughput: one transaction at a time; in_ready is low until the result is taken.
// Reset (synchronous, rst_n low) clears the total size register; the first cycle after
// reset writes one free block of size zero at offset zero, with in_ready low.
module best_fit_block_allocator
  import bfa_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = MaxBlocksDefault,
  parameter int unsigned ADDR_BITS  = AddrBitsDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [OpW-1:0]     in_operation,
  input  logic [FieldW-1:0]  in_block_offset,
  input  logic [FieldW-1:0]  in_block_size,
  input  logic [FieldW-1:0]  in_request_size,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [StatusW-1:0] out_status,
  output logic [FieldW-1:0]  out_result_offset,
  output logic [FieldW-1:0]  out_result_size,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [FieldW-1:0]  cfg_total_size
);

  localparam int unsigned IW = $clog2(MAX_BLOCKS);
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned AW = ADDR_BITS;
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_BLOCKS);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_SCAN  = 11'b00000000010,
    S_CHECK = 11'b00000000100,
    S_RDNB  = 11'b00000001000,
    S_RDNX  = 11'b00000010000,
    S_DEC   = 11'b00000100000,
    S_SHIFT = 11'b00001000000,
    S_WR    = 11'b00010000000,
    S_ERASE = 11'b00100000000,
    S_OUT   = 11'b01000000000,
    S_INIT  = 11'b10000000000
  } state_t;

  // Entry memory: one write port, one registered read port.
  logic [AW-1:0] mem_off [MAX_BLOCKS];
  logic [AW-1:0] mem_sz  [MAX_BLOCKS];
  logic          mem_fr  [MAX_BLOCKS];
  logic [AW-1:0] rd_off, rd_sz;
  logic          rd_fr;
  logic          we;
  logic [IW-1:0] wa, ra;
  logic [AW-1:0] wd_off, wd_sz;
  logic          wd_fr;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_off[wa] <= wd_off;
      mem_sz[wa]  <= wd_sz;
      mem_fr[wa]  <= wd_fr;
    end
    rd_off <= mem_off[ra];
    rd_sz  <= mem_sz[ra];
    rd_fr  <= mem_fr[ra];
  end

  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;     // scan address; read data is for idx_r-1
  logic [CW-1:0]   pos_r, pos_nxt;     // found entry
  logic            hit_r, hit_nxt;
  logic [AW-1:0]   bsz_r, bsz_nxt;     // best size or found entry size
  logic [AW-1:0]   boff_r, boff_nxt;
  logic [AW-1:0]   prsz_r, prsz_nxt;   // previous neighbour size
  logic            prfr_r, prfr_nxt;
  logic [OpW-1:0]  op_r;
  logic [AW-1:0]   qoff_r, qsz_r, req_r;
  logic [FieldW-1:0] tot_r;
  // Pending edit: the slot opened or removed and the entry written afterwards.
  logic [CW-1:0]   epos_r, epos_nxt;
  logic [AW-1:0]   eoff_r, eoff_nxt, esz_r, esz_nxt;
  logic            efr_r, efr_nxt;
  logic [CW-1:0]   ptr_r, ptr_nxt;
  logic            sv_r, sv_nxt;        // shift read data pending
  logic [StatusW-1:0] st_r, st_nxt;
  logic [FieldW-1:0]  roff_r, roff_nxt, rsz_r, rsz_nxt;
  logic            ov_r, ov_nxt;

  logic in_acc, scan_hit;
  logic [AW-1:0] extra;

  assign in_acc    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE) && !ov_r;
  assign cfg_ready = 1'b1;
  assign out_valid = ov_r;
  assign out_status = st_r;
  assign out_result_offset = roff_r;
  assign out_result_size   = rsz_r;
  assign extra = req_r - qsz_r;
  assign scan_hit = (op_r == OP_ALLOC) ? (rd_fr && rd_sz >= req_r && (!hit_r || rd_sz < bsz_r))
                                       : (!rd_fr && rd_off == qoff_r && rd_sz == qsz_r);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_operation;
      qoff_r <= AW'(in_block_offset);
      qsz_r  <= AW'(in_block_size);
      req_r  <= AW'(in_request_size);
    end
    bsz_r <= bsz_nxt; boff_r <= boff_nxt; prsz_r <= prsz_nxt; prfr_r <= prfr_nxt;
    eoff_r <= eoff_nxt; esz_r <= esz_nxt; efr_r <= efr_nxt;
    st_r <= st_nxt; roff_r <= roff_nxt; rsz_r <= rsz_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;  // first cycle writes the reset entry
      cnt_r <= CW'(1); idx_r <= '0; pos_r <= '0; hit_r <= 1'b0;
      epos_r <= '0; ptr_r <= '0; sv_r <= 1'b0;
      ov_r <= 1'b0; tot_r <= '0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; idx_r <= idx_nxt; pos_r <= pos_nxt;
      hit_r <= hit_nxt; epos_r <= epos_nxt; ptr_r <= ptr_nxt;
      sv_r <= sv_nxt; ov_r <= ov_nxt;
      if (cfg_valid) tot_r <= cfg_total_size;
    end
  end

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; idx_nxt = idx_r; pos_nxt = pos_r;
    hit_nxt = hit_r; bsz_nxt = bsz_r; boff_nxt = boff_r; prsz_nxt = prsz_r;
    prfr_nxt = prfr_r; epos_nxt = epos_r; eoff_nxt = eoff_r;
    esz_nxt = esz_r; efr_nxt = efr_r; ptr_nxt = ptr_r; sv_nxt = 1'b0;
    st_nxt = st_r; roff_nxt = roff_r; rsz_nxt = rsz_r;
    ov_nxt = ov_r && !out_ready;
    we = 1'b0; wa = '0; wd_off = eoff_r; wd_sz = esz_r; wd_fr = efr_r;
    ra = idx_r[IW-1:0];
    case (state_r)
      S_INIT: begin
        we = 1'b1; wa = '0; wd_off = '0; wd_sz = '0; wd_fr = 1'b1;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        ra = '0;
        if (in_acc) begin
          st_nxt = ST_OK; roff_nxt = '0; rsz_nxt = '0; hit_nxt = 1'b0;
          idx_nxt = '0;
          if (in_operation == OP_RESET) begin
            eoff_nxt = '0; esz_nxt = AW'(tot_r); efr_nxt = 1'b1;
            epos_nxt = '0; cnt_nxt = '0;
            state_nxt = S_WR;
          end else if (in_operation == OP_ALLOC || in_operation == OP_FREE ||
                       in_operation == OP_CONTAINS || in_operation == OP_RESIZE) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_SCAN: begin
        // idx_r-1 was issued last cycle; its read data is now valid.
        if (idx_r != '0 && scan_hit && !(op_r != OP_ALLOC && hit_r)) begin
          hit_nxt = 1'b1; pos_nxt = idx_r - CW'(1);
          bsz_nxt = rd_sz; boff_nxt = rd_off;
        end
        if (idx_r == cnt_r) state_nxt = S_CHECK;
        else begin
          ra = idx_r[IW-1:0];
          idx_nxt = idx_r + CW'(1);
        end
      end
      S_CHECK: begin
        state_nxt = S_OUT;
        case (op_r)
          OP_ALLOC: begin
            if (!hit_r) st_nxt = ST_NOROOM;
            else if (bsz_r > req_r && cnt_r >= MaxCnt) st_nxt = ST_FULL;
            else begin
              roff_nxt = FieldW'(boff_r); rsz_nxt = FieldW'(req_r);
              we = 1'b1; wa = pos_r[IW-1:0];
              wd_off = boff_r; wd_sz = req_r; wd_fr = 1'b0;
              if (bsz_r > req_r) begin
                epos_nxt = pos_r + CW'(1);
                eoff_nxt = boff_r + req_r; esz_nxt = bsz_r - req_r; efr_nxt = 1'b1;
                ptr_nxt = cnt_r; state_nxt = S_SHIFT;
              end
            end
          end
          OP_CONTAINS: if (!hit_r) st_nxt = ST_NOTFOUND;
          OP_FREE: begin
            if (!hit_r) st_nxt = ST_NOTFOUND;
            else begin
              idx_nxt = pos_r; state_nxt = S_RDNB;
              ra = (pos_r == '0) ? '0 : IW'(pos_r - CW'(1));
            end
          end
          default: begin  // resize
            if (!hit_r) st_nxt = ST_NOTFOUND;
            else if (req_r == qsz_r) begin
              roff_nxt = FieldW'(qoff_r); rsz_nxt = FieldW'(qsz_r);
            end else if (req_r < qsz_r) begin
              if (cnt_r >= MaxCnt) st_nxt = ST_FULL;
              else begin
                roff_nxt = FieldW'(qoff_r); rsz_nxt = FieldW'(req_r);
                we = 1'b1; wa = pos_r[IW-1:0];
                wd_off = qoff_r; wd_sz = req_r; wd_fr = 1'b0;
                epos_nxt = pos_r + CW'(1);
                eoff_nxt = qoff_r + req_r; esz_nxt = qsz_r - req_r; efr_nxt = 1'b1;
                ptr_nxt = cnt_r; state_nxt = S_SHIFT;
              end
            end else begin
              idx_nxt = pos_r; state_nxt = S_RDNX;
              ra = IW'(pos_r + CW'(1));
            end
          end
        endcase
      end
      S_RDNB: begin
        // Previous neighbour arrives; issue the next neighbour read.
        prsz_nxt = rd_sz; prfr_nxt = rd_fr && (pos_r != '0);
        eoff_nxt = rd_off;
        ra = IW'(pos_r + CW'(1));
        state_nxt = S_DEC;
      end
      S_RDNX: begin
        // Hold the next neighbour address so its data arrives in S_DEC.
        ra = IW'(pos_r + CW'(1));
        state_nxt = S_DEC;
      end
      S_DEC: begin
        state_nxt = S_OUT;
        if (op_r == OP_FREE) begin
          if (prfr_r) begin
            // Merge into the previous entry, then erase one or two entries.
            we = 1'b1; wa = IW'(pos_r - CW'(1)); wd_fr = 1'b1;
            epos_nxt = pos_r; ptr_nxt = pos_r;
            if (pos_r + CW'(1) < cnt_r && rd_fr) begin
              wd_sz = prsz_r + bsz_r + rd_sz; hit_nxt = 1'b1;
            end else begin
              wd_sz = prsz_r + bsz_r; hit_nxt = 1'b0;
            end
            wd_off = eoff_r;
            state_nxt = S_ERASE;
          end else begin
            we = 1'b1; wa = pos_r[IW-1:0]; wd_off = boff_r; wd_fr = 1'b1;
            if (pos_r + CW'(1) < cnt_r && rd_fr) begin
              wd_sz = bsz_r + rd_sz;
              epos_nxt = pos_r + CW'(1); ptr_nxt = pos_r + CW'(1);
              hit_nxt = 1'b0; state_nxt = S_ERASE;
            end else wd_sz = bsz_r;
          end
        end else begin
          if (pos_r + CW'(1) < cnt_r && rd_fr && rd_sz >= extra) begin
            roff_nxt = FieldW'(qoff_r); rsz_nxt = FieldW'(req_r);
            we = 1'b1; wa = pos_r[IW-1:0]; wd_off = qoff_r; wd_sz = req_r; wd_fr = 1'b0;
            if (rd_sz > extra) begin
              eoff_nxt = rd_off + extra; esz_nxt = rd_sz - extra; efr_nxt = 1'b1;
              epos_nxt = pos_r + CW'(1); state_nxt = S_WR;
            end else begin
              epos_nxt = pos_r + CW'(1); ptr_nxt = pos_r + CW'(1);
              hit_nxt = 1'b0; state_nxt = S_ERASE;
            end
          end else st_nxt = ST_NOROOM;
        end
      end
      S_SHIFT: begin
        // Insert: move entries up one slot, from the top down to epos_r.
        // The entry read at ptr_r last cycle lands one slot higher, at ptr_r+1.
        if (sv_r) begin
          we = 1'b1; wa = IW'(ptr_r + CW'(1));
          wd_off = rd_off; wd_sz = rd_sz; wd_fr = rd_fr;
        end
        if (ptr_r == epos_r) begin
          cnt_nxt = cnt_r + CW'(1); state_nxt = S_WR;
        end else begin
          ra = IW'(ptr_r - CW'(1));
          sv_nxt = 1'b1;
          ptr_nxt = ptr_r - CW'(1);
        end
      end
      S_ERASE: begin
        // Erase: move entries down one slot; hit_r asks for a second pass.
        if (sv_r) begin
          we = 1'b1; wa = IW'(ptr_r - CW'(1));
          wd_off = rd_off; wd_sz = rd_sz; wd_fr = rd_fr;
        end
        if (ptr_r + CW'(1) >= cnt_r) begin
          cnt_nxt = cnt_r - CW'(1);
          if (hit_r) begin
            hit_nxt = 1'b0; ptr_nxt = epos_r;
          end else state_nxt = S_OUT;
        end else begin
          ra = IW'(ptr_r + CW'(1));
          sv_nxt = 1'b1;
          ptr_nxt = ptr_r + CW'(1);
        end
      end
      S_WR: begin
        we = 1'b1; wa = IW'(epos_r);
        if (op_r == OP_RESET || cnt_r == '0) cnt_nxt = CW'(1);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        ov_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

/* sv/bfa_checker.sv */
module bfa_checker
  import bfa_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [StatusW-1:0] out_status,
  input logic [FieldW-1:0]  out_result_offset,
  input logic [FieldW-1:0]  out_result_size
);

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while a result waits");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_size))
    else $error("result dropped before transaction");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_result_offset == '0 && out_result_size == '0)
    else $error("failed operation returned a block");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("ready after accept");

endmodule

bind best_fit_block_allocator bfa_checker u_bfa_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
  .out_result_offset(out_result_offset), .out_result_size(out_result_size)
);

/* tb/best_fit_block_allocator_test.sv */
module best_fit_block_allocator_test;
  import bfa_pkg::*;

  localparam int unsigned Slots = MaxBlocksDefault;
  localparam logic [OpW-1:0] OpUnusedFirst = 3'd5;
  localparam logic [OpW-1:0] OpUnusedLast = 3'd7;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned SettleCycles = 3 * Slots + 16;
  localparam int unsigned RandomItems = 1200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OpW-1:0] in_operation = '0;
  logic [FieldW-1:0] in_block_offset = '0;
  logic [FieldW-1:0] in_block_size = '0;
  logic [FieldW-1:0] in_request_size = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [StatusW-1:0] out_status;
  logic [FieldW-1:0] out_result_offset;
  logic [FieldW-1:0] out_result_size;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [FieldW-1:0] cfg_total_size = '0;

  best_fit_block_allocator dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_operation(in_operation),
    .in_block_offset(in_block_offset),
    .in_block_size(in_block_size),
    .in_request_size(in_request_size),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_result_offset(out_result_offset),
    .out_result_size(out_result_size),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_total_size(cfg_total_size)
  );

  always #4 clk = ~clk;

  // Shadow copy of the block table and the size register.
  logic [FieldW-1:0] blk_off[Slots];
  logic [FieldW-1:0] blk_size[Slots];
  logic blk_free[Slots];
  int blk_count;
  logic [FieldW-1:0] buffer_size;

  status_t pending_status[$];
  logic [FieldW-1:0] pending_offset[$];
  logic [FieldW-1:0] pending_size[$];

  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int idle_cycles = 0;

  typedef struct {
    logic wr_cfg;
    logic [OpW-1:0] op;
    logic [FieldW-1:0] offset;
    logic [FieldW-1:0] size;
    logic [FieldW-1:0] request;
    logic known;
    status_t status;
    logic [FieldW-1:0] res_off;
    logic [FieldW-1:0] res_size;
  } row_t;

  row_t directed[] = '{
    '{1'b0, OP_ALLOC, 32'd0, 32'd0, 32'd0, 1'b1, ST_OK, 32'd0, 32'd0},
    '{1'b0, OP_ALLOC, 32'd0, 32'd0, 32'd1, 1'b1, ST_NOROOM, 32'd0, 32'd0},
    '{1'b0, OP_CONTAINS, 32'd0, 32'd0, 32'd0, 1'b1, ST_OK, 32'd0, 32'd0},
    '{1'b0, OP_FREE, 32'd0, 32'd0, 32'd0, 1'b1, ST_OK, 32'd0, 32'd0},
    '{1'b0, OP_CONTAINS, 32'd0, 32'd0, 32'd0, 1'b1, ST_NOTFOUND, 32'd0, 32'd0},
    '{1'b0, OpUnusedFirst, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, ST_OK, 32'd0, 32'd0},
    '{1'b0, OpUnusedLast, 32'd0, 32'd0, 32'd0, 1'b1, ST_OK, 32'd0, 32'd0},
    '{1'b1, OP_ALLOC, 32'hFFFFFFFF, 32'd0, 32'd0, 1'b0, ST_OK, 32'd0, 32'd0},
    '{1'b0, OP_RESET, 32'd0, 32'd0, 32'd0, 1'b1, ST_OK, 32'd0, 32'd0},
    '{1'b0, OP_ALLOC, 32'd0, 32'd0, 32'hFFFFFFFF, 1'b1, ST_OK, 32'd0, 32'hFFFFFFFF},
    '{1'b0, OP_ALLOC, 32'd0, 32'd0, 32'd0, 1'b1, ST_NOROOM, 32'd0, 32'd0},
    '{1'b0, OP_RESIZE, 32'd0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, ST_OK, 32'd0, 32'hFFFFFFFF},
    '{1'b0, OP_RESIZE, 32'd0, 32'hFFFFFFFF, 32'd16, 1'b0, ST_OK, 32'd0, 32'd0},
    '{1'b0, OP_ALLOC, 32'd0, 32'd0, 32'd0, 1'b0, ST_OK, 32'd0, 32'd0},
    '{1'b0, OP_ALLOC, 32'd0, 32'd0, 32'd8, 1'b0, ST_OK, 32'd0, 32'd0},
    '{1'b0, OP_RESIZE, 32'd0, 32'd16, 32'd32, 1'b0, ST_OK, 32'd0, 32'd0},
    '{1'b0, OP_RESIZE, 32'd16, 32'd0, 32'hFFFFFFF0, 1'b0, ST_OK, 32'd0, 32'd0},
    '{1'b0, OP_FREE, 32'd16, 32'd0, 32'd0, 1'b0, ST_OK, 32'd0, 32'd0},
    '{1'b0, OP_FREE, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd0, 1'b1, ST_NOTFOUND, 32'd0, 32'd0},
    '{1'b0, OP_RESIZE, 32'h12345678, 32'd5, 32'd9, 1'b1, ST_NOTFOUND, 32'd0, 32'd0},
    '{1'b0, OP_FREE, 32'd0, 32'd16, 32'd0, 1'b0, ST_OK, 32'd0, 32'd0},
    '{1'b0, OP_RESET, 32'd0, 32'd0, 32'd0, 1'b1, ST_OK, 32'd0, 32'd0}
  };

  task automatic restore_table();
    for (int i = 0; i < Slots; i++) begin
      blk_off[i] = '0;
      blk_size[i] = '0;
      blk_free[i] = 1'b0;
    end
    blk_size[0] = buffer_size;
    blk_free[0] = 1'b1;
    blk_count = 1;
  endtask

  task automatic open_slot(input int pos, input logic [FieldW-1:0] off,
                           input logic [FieldW-1:0] sz);
    for (int i = blk_count; i > pos; i--) begin
      blk_off[i] = blk_off[i-1];
      blk_size[i] = blk_size[i-1];
      blk_free[i] = blk_free[i-1];
    end
    blk_off[pos] = off;
    blk_size[pos] = sz;
    blk_free[pos] = 1'b1;
    blk_count++;
  endtask

  task automatic close_slot(input int pos);
    for (int i = pos; i < blk_count - 1; i++) begin
      blk_off[i] = blk_off[i+1];
      blk_size[i] = blk_size[i+1];
      blk_free[i] = blk_free[i+1];
    end
    blk_count--;
  endtask

  function automatic int find_used_block(input logic [FieldW-1:0] off,
                                         input logic [FieldW-1:0] sz);
    for (int i = 0; i < blk_count; i++)
      if (!blk_free[i] && blk_off[i] == off && blk_size[i] == sz) return i;
    return -1;
  endfunction

  task automatic apply_operation(input logic [OpW-1:0] op, input logic [FieldW-1:0] boff,
                                 input logic [FieldW-1:0] bsz,
                                 input logic [FieldW-1:0] req, output status_t st,
                                 output logic [FieldW-1:0] roff,
                                 output logic [FieldW-1:0] rsz);
    int best;
    int idx;
    logic [FieldW-1:0] extra;
    st = ST_OK;
    roff = '0;
    rsz = '0;
    case (op)
      OP_ALLOC: begin
        best = -1;
        for (int i = 0; i < blk_count; i++)
          if (blk_free[i] && blk_size[i] >= req && (best < 0 || blk_size[i] < blk_size[best]))
            best = i;
        if (best < 0) begin
          st = ST_NOROOM;
        end else if (blk_size[best] > req && blk_count >= Slots) begin
          st = ST_FULL;
        end else begin
          if (blk_size[best] > req) begin
            open_slot(best + 1, blk_off[best] + req, blk_size[best] - req);
            blk_size[best] = req;
          end
          blk_free[best] = 1'b0;
          roff = blk_off[best];
          rsz = req;
        end
      end
      OP_FREE: begin
        idx = find_used_block(boff, bsz);
        if (idx < 0) begin
          st = ST_NOTFOUND;
        end else begin
          blk_free[idx] = 1'b1;
          if (idx > 0 && blk_free[idx-1]) begin
            blk_size[idx-1] = blk_size[idx-1] + blk_size[idx];
            close_slot(idx);
            idx--;
          end
          if (idx + 1 < blk_count && blk_free[idx+1]) begin
            blk_size[idx] = blk_size[idx] + blk_size[idx+1];
            close_slot(idx + 1);
          end
        end
      end
      OP_CONTAINS: begin
        if (find_used_block(boff, bsz) < 0) st = ST_NOTFOUND;
      end
      OP_RESIZE: begin
        idx = find_used_block(boff, bsz);
        if (idx < 0) begin
          st = ST_NOTFOUND;
        end else if (req == bsz) begin
          roff = boff;
          rsz = bsz;
        end else if (req < bsz) begin
          if (blk_count >= Slots) begin
            st = ST_FULL;
          end else begin
            blk_size[idx] = req;
            open_slot(idx + 1, boff + req, bsz - req);
            roff = boff;
            rsz = req;
          end
        end else begin
          extra = req - bsz;
          if (idx + 1 < blk_count && blk_free[idx+1] && blk_size[idx+1] >= extra) begin
            blk_size[idx] = req;
            if (blk_size[idx+1] > extra) begin
              blk_off[idx+1] = blk_off[idx+1] + extra;
              blk_size[idx+1] = blk_size[idx+1] - extra;
            end else begin
              close_slot(idx + 1);
            end
            roff = boff;
            rsz = req;
          end else begin
            st = ST_NOROOM;
          end
        end
      end
      OP_RESET: restore_table();
      default: ;
    endcase
  endtask

  // Drives one transaction and updates the shadow table once it is accepted.
  task automatic send_item(input logic [OpW-1:0] op, input logic [FieldW-1:0] boff,
                           input logic [FieldW-1:0] bsz, input logic [FieldW-1:0] req,
                           input logic known, input status_t k_st,
                           input logic [FieldW-1:0] k_off, input logic [FieldW-1:0] k_size);
    int gap;
    status_t st;
    logic [FieldW-1:0] roff;
    logic [FieldW-1:0] rsz;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_block_offset <= boff;
    in_block_size <= bsz;
    in_request_size <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_operation(op, boff, bsz, req, st, roff, rsz);
    if (known) begin
      st = k_st;
      roff = k_off;
      rsz = k_size;
    end
    pending_status = {pending_status, st};
    pending_offset = {pending_offset, roff};
    pending_size = {pending_size, rsz};
  endtask

  task automatic write_buffer_size(input logic [FieldW-1:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_status.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_total_size <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    buffer_size = value;
  endtask

  task automatic send_random(input int alloc_pct);
    logic [OpW-1:0] op;
    logic [FieldW-1:0] boff;
    logic [FieldW-1:0] bsz;
    logic [FieldW-1:0] req;
    int pick;
    int roll;
    int used[$];
    roll = $urandom_range(99);
    if (roll < alloc_pct) op = OP_ALLOC;
    else if (roll < alloc_pct + 22) op = OP_FREE;
    else if (roll < alloc_pct + 32) op = OP_CONTAINS;
    else if (roll < 96) op = OP_RESIZE;
    else if (roll < 98) op = OP_RESET;
    else op = OpW'($urandom_range(OpUnusedFirst, OpUnusedLast));
    used.delete();
    for (int i = 0; i < blk_count; i++) if (!blk_free[i]) used = {used, i};
    if (used.size() > 0 && $urandom_range(99) < 85) begin
      pick = used[$urandom_range(used.size() - 1)];
      boff = blk_off[pick];
      bsz = blk_size[pick];
    end else begin
      boff = $urandom();
      bsz = $urandom();
    end
    case ($urandom_range(9))
      0: req = $urandom();
      1: req = bsz;
      2: req = bsz + $urandom_range(0, 40);
      3: req = '0;
      default: req = $urandom_range(0, 40);
    endcase
    if (op == OP_RESIZE && $urandom_range(1) == 1) req = bsz - $urandom_range(0, bsz > 8 ? 8 : bsz);
    send_item(op, boff, bsz, req, 1'b0, ST_OK, '0, '0);
  endtask

  // Results are checked in order; the ready line is redrawn every cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_status.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transaction: status %0d", out_status);
        end else begin
          if (out_status !== pending_status[0] || out_result_offset !== pending_offset[0] ||
              out_result_size !== pending_size[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected status %0d offset %h size %h, got %0d %h %h",
                       pending_status[0], pending_offset[0], pending_size[0], out_status,
                       out_result_offset, out_result_size);
          end
          void'(pending_status.pop_front());
          void'(pending_offset.pop_front());
          void'(pending_size.pop_front());
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("best_fit_block_allocator_test failed");
        $finish;
      end
    end
  end

  initial begin
    logic [FieldW-1:0] sizes[4];
    buffer_size = '0;
    restore_table();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[r]) begin
      if (directed[r].wr_cfg)
        write_buffer_size(directed[r].offset);
      else
        send_item(directed[r].op, directed[r].offset, directed[r].size, directed[r].request,
                  directed[r].known, directed[r].status, directed[r].res_off,
                  directed[r].res_size);
    end
    sizes[0] = $urandom_range(40, 400);
    sizes[1] = 32'hFFFFFFFF;
    sizes[2] = $urandom_range(100, 2000);
    sizes[3] = $urandom();
    for (int ph = 0; ph < 4; ph++) begin
      write_buffer_size(sizes[ph]);
      send_idle_pct = (ph == 1) ? 46 : (ph == 3) ? 38 : 0;
      recv_stall_pct = (ph == 2) ? 46 : (ph == 3) ? 38 : 0;
      send_item(OP_RESET, '0, '0, '0, 1'b0, ST_OK, '0, '0);
      // Small allocations first, so that the table fills up and splits hit the limit.
      for (int n = 0; n < 80; n++)
        send_item(OP_ALLOC, $urandom(), $urandom(), $urandom_range(0, 3), 1'b0, ST_OK, '0, '0);
      for (int n = 0; n < RandomItems / 4 - 80; n++) send_random(ph == 0 ? 30 : 40);
    end
    write_buffer_size('0);
    send_item(OP_RESET, '0, '0, '0, 1'b0, ST_OK, '0, '0);
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0 && pending_status.size() == 0)
      $display("best_fit_block_allocator_test passed");
    else
      $display("best_fit_block_allocator_test failed");
    $finish;
  end

endmodule
